// ===== sv/polyline_direction_color_top_defines.svh =====
// Assertion macros for the polyline direction colour block.
// Used by the port checker; no other dependencies.
`ifndef POLYLINE_DIRECTION_COLOR_TOP_DEFINES_SVH
`define POLYLINE_DIRECTION_COLOR_TOP_DEFINES_SVH

// Implication checked on every rising edge outside reset.
`define PDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication checked on every rising edge outside reset.
`define PDC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/pdc_pkg.sv =====
// Shared constants and types for the polyline direction colour block.
// No dependencies.
package pdc_pkg;
  localparam int COORD_BITS = 24;
  localparam int UNIT_BITS  = 16;
  localparam int DIFF_W     = COORD_BITS + 1;
  localparam int NORM_W     = 25;
  localparam int SQ_W       = 2 * NORM_W + 2;
  localparam int ROOT_W     = NORM_W + 1;
  localparam int REM_W      = ROOT_W + 1;
  localparam int MAG_W      = UNIT_BITS - 1;
  localparam int CNT_W      = $clog2((ROOT_W > UNIT_BITS) ? ROOT_W : UNIT_BITS);

  typedef struct packed {
    logic done;
    logic deg;
  } pdc_norm_res_t;
endpackage

// ===== sv/polyline_direction_color_top.sv =====
// Polyline direction colour: each later vertex of a line takes one normalisation (two at
// a line's end, one for the tangent and one for the global colour) on the shared iterative
// unit in pdc_norm. A normalisation shifts the components up, accumulates their squares,
// takes the square root and divides each component by it; a zero vector skips these
// steps and is flagged degenerate. in_ready is low while a vertex is in work.
// A start vertex without end gives no result and is taken at once.
// Depends on pdc_pkg and pdc_norm.
module polyline_direction_color_top import pdc_pkg::*; (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic signed [COORD_BITS-1:0] in_pos_x,
  input  logic signed [COORD_BITS-1:0] in_pos_y,
  input  logic signed [COORD_BITS-1:0] in_pos_z,
  input  logic                        in_line_start,
  input  logic                        in_line_end,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic signed [UNIT_BITS-1:0] out_tangent_x,
  output logic signed [UNIT_BITS-1:0] out_tangent_y,
  output logic signed [UNIT_BITS-1:0] out_tangent_z,
  output logic        [MAG_W-1:0]     out_local_red,
  output logic        [MAG_W-1:0]     out_local_green,
  output logic        [MAG_W-1:0]     out_local_blue,
  output logic                        out_global_valid,
  output logic        [MAG_W-1:0]     out_global_red,
  output logic        [MAG_W-1:0]     out_global_green,
  output logic        [MAG_W-1:0]     out_global_blue,
  output logic                        out_degenerate,
  output logic                        out_run_last
);
  typedef enum logic [2:0] {S_IDLE, S_T_GO, S_T_WAIT, S_G_GO, S_G_WAIT, S_EMIT1, S_EMIT2}
    state_t;
  typedef enum logic [1:0] {PH_IDLE, PH_FIRST, PH_RUN} phase_t;

  state_t  state_r;
  phase_t  phase_r;
  logic signed [COORD_BITS-1:0] prev_r [3], first_r [3], v_r [3];
  logic    end_r;
  logic [MAG_W-1:0] t_mag_r [3], g_mag_r [3];
  logic    t_neg_r [3];
  logic    tdeg_r, gdeg_r;

  logic                    out_valid_r, gv_r, deg_o_r, rl_r;
  logic signed [UNIT_BITS-1:0] tan_r [3];
  logic [MAG_W-1:0]        lc_r [3], gc_r [3];

  logic signed [COORD_BITS-1:0] vin [3];
  logic signed [DIFF_W-1:0] nd [3];
  logic [MAG_W-1:0]  n_mag [3];
  logic              n_neg [3];
  pdc_norm_res_t     n_res;
  logic              n_start, slot_free, acc;

  assign vin[0]    = in_pos_x;
  assign vin[1]    = in_pos_y;
  assign vin[2]    = in_pos_z;
  assign in_ready  = (state_r == S_IDLE);
  assign acc       = in_valid && in_ready;
  assign slot_free = !out_valid_r || out_ready;
  assign n_start   = (state_r == S_T_GO) || (state_r == S_G_GO);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (state_r == S_G_GO)
        nd[i] = DIFF_W'(first_r[i]) - DIFF_W'(v_r[i]);
      else
        nd[i] = DIFF_W'(prev_r[i]) - DIFF_W'(v_r[i]);
    end
  end

  pdc_norm u_norm (
    .clk   (clk),
    .rst_n (rst_n),
    .start (n_start),
    .d     (nd),
    .mag   (n_mag),
    .neg   (n_neg),
    .res   (n_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= PH_IDLE;
      out_valid_r <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        prev_r[i]  <= '0;
        first_r[i] <= '0;
      end
    end else begin
      if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (acc) begin
            for (int i = 0; i < 3; i++) v_r[i] <= vin[i];
            end_r <= in_line_end;
            if (in_line_start) begin
              for (int i = 0; i < 3; i++) begin
                first_r[i] <= vin[i];
                prev_r[i]  <= vin[i];
              end
              if (in_line_end) begin
                for (int i = 0; i < 3; i++) begin
                  t_mag_r[i] <= '0;
                  t_neg_r[i] <= 1'b0;
                  g_mag_r[i] <= '0;
                end
                tdeg_r  <= 1'b1;
                gdeg_r  <= 1'b0;
                phase_r <= PH_RUN;
                state_r <= S_EMIT2;
              end else begin
                phase_r <= PH_FIRST;
              end
            end else if (phase_r != PH_IDLE) begin
              state_r <= S_T_GO;
            end
          end
        end
        S_T_GO: state_r <= S_T_WAIT;
        S_T_WAIT: begin
          if (n_res.done) begin
            t_mag_r <= n_mag;
            t_neg_r <= n_neg;
            tdeg_r  <= n_res.deg;
            gdeg_r  <= 1'b0;
            for (int i = 0; i < 3; i++) g_mag_r[i] <= '0;
            if (end_r) state_r <= S_G_GO;
            else state_r <= (phase_r == PH_FIRST) ? S_EMIT1 : S_EMIT2;
          end
        end
        S_G_GO: state_r <= S_G_WAIT;
        S_G_WAIT: begin
          if (n_res.done) begin
            g_mag_r <= n_mag;
            gdeg_r  <= n_res.deg;
            state_r <= (phase_r == PH_FIRST) ? S_EMIT1 : S_EMIT2;
          end
        end
        S_EMIT1: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              tan_r[i] <= t_neg_r[i] ? -UNIT_BITS'(t_mag_r[i]) : UNIT_BITS'(t_mag_r[i]);
              lc_r[i]  <= t_mag_r[i];
              gc_r[i]  <= '0;
            end
            gv_r    <= 1'b0;
            deg_o_r <= tdeg_r;
            rl_r    <= 1'b0;
            state_r <= S_EMIT2;
          end
        end
        S_EMIT2: begin
          if (slot_free) begin
            out_valid_r <= 1'b1;
            for (int i = 0; i < 3; i++) begin
              tan_r[i]  <= t_neg_r[i] ? -UNIT_BITS'(t_mag_r[i]) : UNIT_BITS'(t_mag_r[i]);
              lc_r[i]   <= t_mag_r[i];
              gc_r[i]   <= g_mag_r[i];
              prev_r[i] <= v_r[i];
            end
            gv_r    <= end_r;
            deg_o_r <= tdeg_r || gdeg_r;
            rl_r    <= 1'b1;
            phase_r <= end_r ? PH_IDLE : PH_RUN;
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid        = out_valid_r;
  assign out_tangent_x    = tan_r[0];
  assign out_tangent_y    = tan_r[1];
  assign out_tangent_z    = tan_r[2];
  assign out_local_red    = lc_r[0];
  assign out_local_green  = lc_r[1];
  assign out_local_blue   = lc_r[2];
  assign out_global_valid = gv_r;
  assign out_global_red   = gc_r[0];
  assign out_global_green = gc_r[1];
  assign out_global_blue  = gc_r[2];
  assign out_degenerate   = deg_o_r;
  assign out_run_last     = rl_r;
endmodule

// ===== sv/pdc_norm.sv =====
// Iterative vector normaliser: shift, sum of squares, square root, divide.
// Depends on pdc_pkg.
module pdc_norm import pdc_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic signed [DIFF_W-1:0] d [3],
  output logic        [MAG_W-1:0]  mag [3],
  output logic                     neg [3],
  output pdc_norm_res_t            res
);
  typedef enum logic [2:0] {N_IDLE, N_SHIFT, N_SQ, N_SQRT, N_DIV} nstate_t;

  nstate_t           state_r;
  logic [NORM_W-1:0] a_r [3];
  logic [SQ_W-1:0]   s_r;
  logic [ROOT_W-1:0] root_r;
  logic [REM_W-1:0]  rem_r;
  logic [UNIT_BITS-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [1:0]        idx_r;
  logic              done_r, deg_r;
  logic [MAG_W-1:0]  mag_r [3];
  logic              neg_r [3];

  logic [2*NORM_W-1:0] prod;
  logic [REM_W+1:0]    rt_sh, rt_trial;
  logic                rt_ge;
  logic                dv_ge;
  logic [REM_W-1:0]    dv_rem;
  logic [UNIT_BITS-1:0] dv_q;
  logic [NORM_W-1:0]   abs_d [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      abs_d[i] = d[i][DIFF_W-1] ? NORM_W'(-d[i]) : NORM_W'(d[i]);
    end
    prod     = a_r[idx_r] * a_r[idx_r];
    rt_sh    = {rem_r, s_r[SQ_W-1 -: 2]};
    rt_trial = {1'b0, root_r, 2'b01};
    rt_ge    = rt_sh >= rt_trial;
    dv_ge    = rem_r >= {1'b0, root_r};
    dv_rem   = dv_ge ? (rem_r - {1'b0, root_r}) : rem_r;
    dv_q     = {q_r[UNIT_BITS-2:0], dv_ge};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= N_IDLE;
      done_r  <= 1'b0;
    end else begin
      done_r <= 1'b0;
      case (state_r)
        N_IDLE: begin
          if (start) begin
            for (int i = 0; i < 3; i++) begin
              a_r[i]   <= abs_d[i];
              neg_r[i] <= d[i][DIFF_W-1];
              mag_r[i] <= '0;
            end
            if ((abs_d[0] | abs_d[1] | abs_d[2]) == '0) begin
              deg_r  <= 1'b1;
              done_r <= 1'b1;
            end else begin
              deg_r   <= 1'b0;
              state_r <= N_SHIFT;
            end
          end
        end
        N_SHIFT: begin
          if (a_r[0][NORM_W-1] | a_r[1][NORM_W-1] | a_r[2][NORM_W-1]) begin
            idx_r   <= '0;
            s_r     <= '0;
            state_r <= N_SQ;
          end else begin
            for (int i = 0; i < 3; i++) a_r[i] <= {a_r[i][NORM_W-2:0], 1'b0};
          end
        end
        N_SQ: begin
          s_r <= s_r + SQ_W'(prod);
          if (idx_r == 2'd2) begin
            rem_r   <= '0;
            root_r  <= '0;
            cnt_r   <= CNT_W'(ROOT_W - 1);
            state_r <= N_SQRT;
          end else begin
            idx_r <= idx_r + 2'd1;
          end
        end
        N_SQRT: begin
          s_r <= {s_r[SQ_W-3:0], 2'b00};
          if (rt_ge) begin
            rem_r  <= REM_W'(rt_sh - rt_trial);
            root_r <= {root_r[ROOT_W-2:0], 1'b1};
          end else begin
            rem_r  <= REM_W'(rt_sh);
            root_r <= {root_r[ROOT_W-2:0], 1'b0};
          end
          if (cnt_r == '0) begin
            idx_r   <= '0;
            rem_r   <= REM_W'(a_r[0]);
            q_r     <= '0;
            cnt_r   <= CNT_W'(UNIT_BITS - 1);
            state_r <= N_DIV;
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        N_DIV: begin
          q_r   <= dv_q;
          rem_r <= {dv_rem[REM_W-2:0], 1'b0};
          if (cnt_r == '0) begin
            mag_r[idx_r] <= dv_q[UNIT_BITS-1] ? {MAG_W{1'b1}} : dv_q[MAG_W-1:0];
            if (idx_r == 2'd2) begin
              done_r  <= 1'b1;
              state_r <= N_IDLE;
            end else begin
              idx_r <= idx_r + 2'd1;
              rem_r <= REM_W'(a_r[idx_r + 2'd1]);
              q_r   <= '0;
              cnt_r <= CNT_W'(UNIT_BITS - 1);
            end
          end else begin
            cnt_r <= cnt_r - 1'b1;
          end
        end
        default: state_r <= N_IDLE;
      endcase
    end
  end

  assign mag = mag_r;
  assign neg = neg_r;
  assign res = '{done: done_r, deg: deg_r};
endmodule

// ===== sv/pdc_checker.sv =====
// Port-level checker for the polyline direction colour block, with its bind.
// Depends on pdc_pkg and the assertion macros header.
`include "polyline_direction_color_top_defines.svh"

module pdc_checker import pdc_pkg::*; (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 out_valid,
  input logic                 out_ready,
  input logic [UNIT_BITS-1:0] out_tangent_x,
  input logic [UNIT_BITS-1:0] out_tangent_y,
  input logic [UNIT_BITS-1:0] out_tangent_z,
  input logic                 out_global_valid,
  input logic [MAG_W-1:0]     out_global_red,
  input logic [MAG_W-1:0]     out_global_green,
  input logic [MAG_W-1:0]     out_global_blue,
  input logic                 out_degenerate,
  input logic                 out_run_last
);
  `PDC_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_tangent_x), "result request dropped or changed while stalled")
  `PDC_ASSERT_IMP(a_first_no_global, out_valid && !out_run_last, !out_global_valid, "global colour on a non-final result")
  `PDC_ASSERT_IMP(a_global_zero, out_valid && !out_global_valid, (out_global_red == '0) && (out_global_green == '0) && (out_global_blue == '0), "global colour set without global_valid")
  `PDC_ASSERT_IMP(a_tangent_live, out_valid && !out_degenerate, (out_tangent_x != '0) || (out_tangent_y != '0) || (out_tangent_z != '0), "zero tangent without degenerate flag")
endmodule

bind polyline_direction_color_top pdc_checker u_pdc_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_ready        (out_ready),
  .out_tangent_x    (out_tangent_x),
  .out_tangent_y    (out_tangent_y),
  .out_tangent_z    (out_tangent_z),
  .out_global_valid (out_global_valid),
  .out_global_red   (out_global_red),
  .out_global_green (out_global_green),
  .out_global_blue  (out_global_blue),
  .out_degenerate   (out_degenerate),
  .out_run_last     (out_run_last)
);

// ===== dv/tb_top.sv =====
// Self-checking testbench for polyline_direction_color_top: drives vertex requests
// and checks every tangent/colour result against an in-bench model of the block.
// Depends on pdc_pkg and the RTL of polyline_direction_color_top.
`timescale 1ns / 1ps
module tb_top;
  import pdc_pkg::*;

  localparam int TIMEOUT_CYCLES = 2000000;
  localparam int STALL_CYCLES   = 3000;
  localparam logic [1:0] PH_IDLE  = 2'd0;
  localparam logic [1:0] PH_FIRST = 2'd1;
  localparam logic [1:0] PH_RUN   = 2'd2;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic signed [COORD_BITS-1:0] z;
    logic start;
    logic fin;
  } vertex_t;

  typedef struct packed {
    logic signed [UNIT_BITS-1:0] tx;
    logic signed [UNIT_BITS-1:0] ty;
    logic signed [UNIT_BITS-1:0] tz;
    logic [MAG_W-1:0] lr;
    logic [MAG_W-1:0] lg;
    logic [MAG_W-1:0] lb;
    logic gv;
    logic [MAG_W-1:0] gr;
    logic [MAG_W-1:0] gg;
    logic [MAG_W-1:0] gb;
    logic deg;
    logic last;
  } colour_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [COORD_BITS-1:0] in_pos_x = '0, in_pos_y = '0, in_pos_z = '0;
  logic in_line_start = 1'b0, in_line_end = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [UNIT_BITS-1:0] out_tangent_x, out_tangent_y, out_tangent_z;
  logic [MAG_W-1:0] out_local_red, out_local_green, out_local_blue;
  logic out_global_valid;
  logic [MAG_W-1:0] out_global_red, out_global_green, out_global_blue;
  logic out_degenerate, out_run_last;

  polyline_direction_color_top dut (.*);

  always #10 clk = ~clk;

  vertex_t pending_vertices[$];
  colour_t expected_colours[$];
  int errors = 0;
  int cycle_count = 0;
  int results_seen = 0;
  int vertices_sent = 0;
  bit stim_done = 0;
  bit calm = 0;
  bit in_taken = 0;
  bit stall_req = 0;
  bit stall_used = 0;
  int hold_off = 0;

  longint prev_pt[3];
  longint first_pt[3];
  logic [1:0] phase = PH_IDLE;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'h4000_0000_0000_0000;
    while (bit_v > v) bit_v >>= 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v -= res + bit_v;
        res = (res >> 1) + bit_v;
      end else begin
        res >>= 1;
      end
      bit_v >>= 2;
    end
    return res;
  endfunction

  // returns 1 on zero length
  function automatic bit unit_vector(input longint d[3], output longint u[3]);
    longint unsigned a[3], m, s, r, q, cap;
    int bl;
    m = 0;
    s = 0;
    bl = 0;
    cap = (64'd1 << (UNIT_BITS - 1)) - 1;
    for (int i = 0; i < 3; i++) begin
      a[i] = d[i] < 0 ? longint'(-d[i]) : longint'(d[i]);
      if (a[i] > m) m = a[i];
    end
    if (m == 0) begin
      u[0] = 0; u[1] = 0; u[2] = 0;
      return 1;
    end
    while (bl < 64 && (m >> bl) != 0) bl++;
    for (int i = 0; i < 3; i++) begin
      if (bl < 25) a[i] <<= (25 - bl);
      else if (bl > 25) a[i] >>= (bl - 25);
      s += a[i] * a[i];
    end
    r = root_floor(s);
    for (int i = 0; i < 3; i++) begin
      q = (a[i] << (UNIT_BITS - 1)) / r;
      if (q > cap) q = cap;
      u[i] = d[i] < 0 ? -longint'(q) : longint'(q);
    end
    return 0;
  endfunction

  function automatic longint mag_of(longint v);
    return v < 0 ? -v : v;
  endfunction

  function automatic colour_t make_colour(longint t[3], bit deg, bit gv, longint g[3],
                                          bit last);
    colour_t c;
    c.tx = UNIT_BITS'(t[0]); c.ty = UNIT_BITS'(t[1]); c.tz = UNIT_BITS'(t[2]);
    c.lr = MAG_W'(mag_of(t[0]));
    c.lg = MAG_W'(mag_of(t[1]));
    c.lb = MAG_W'(mag_of(t[2]));
    c.gv = gv;
    c.gr = gv ? MAG_W'(mag_of(g[0])) : '0;
    c.gg = gv ? MAG_W'(mag_of(g[1])) : '0;
    c.gb = gv ? MAG_W'(mag_of(g[2])) : '0;
    c.deg = deg;
    c.last = last;
    return c;
  endfunction

  task automatic predict_colours(vertex_t v);
    longint p[3], d[3], t[3], g[3], zero[3];
    bit tdeg, gdeg;
    p[0] = v.x; p[1] = v.y; p[2] = v.z;
    zero = '{0, 0, 0};
    g = zero;
    gdeg = 0;
    if (v.start) begin
      first_pt = p;
      prev_pt = p;
      if (v.fin) begin
        expected_colours.push_back(make_colour(zero, 1, 1, zero, 1));
        phase = PH_IDLE;
      end else begin
        phase = PH_FIRST;
      end
      return;
    end
    if (phase == PH_IDLE) return;
    for (int i = 0; i < 3; i++) d[i] = prev_pt[i] - p[i];
    tdeg = unit_vector(d, t);
    if (phase == PH_FIRST) expected_colours.push_back(make_colour(t, tdeg, 0, zero, 0));
    if (v.fin) begin
      for (int i = 0; i < 3; i++) d[i] = first_pt[i] - p[i];
      gdeg = unit_vector(d, g);
    end
    expected_colours.push_back(make_colour(t, tdeg || gdeg, v.fin, g, 1));
    prev_pt = p;
    phase = v.fin ? PH_IDLE : PH_RUN;
  endtask

  function automatic vertex_t mk(longint x, longint y, longint z, bit s, bit e);
    vertex_t v;
    v.x = COORD_BITS'(x); v.y = COORD_BITS'(y); v.z = COORD_BITS'(z);
    v.start = s; v.fin = e;
    return v;
  endfunction

  function automatic logic [COORD_BITS-1:0] rand_coord(int kind);
    case (kind)
      0: return COORD_BITS'($urandom);
      1: return COORD_BITS'($urandom_range(0, 255) - 128);
      2: return ($urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000) ^
                COORD_BITS'($urandom_range(0, 3));
      default: return COORD_BITS'($urandom_range(0, 65535) - 32768);
    endcase
  endfunction

  // driver
  always @(negedge clk) begin
    bit busy;
    busy = in_valid && !in_taken;
    if (rst_n) begin
      if (!busy && pending_vertices.size() != 0 &&
          (calm || $urandom_range(0, 99) >= 36)) begin
        in_pos_x <= pending_vertices[0].x;
        in_pos_y <= pending_vertices[0].y;
        in_pos_z <= pending_vertices[0].z;
        in_line_start <= pending_vertices[0].start;
        in_line_end <= pending_vertices[0].fin;
        in_valid <= 1'b1;
        void'(pending_vertices.pop_front());
      end else if (!busy) begin
        in_valid <= 1'b0;
      end
      if (hold_off > 0) begin
        out_ready <= 1'b0;
      end else begin
        out_ready <= calm || $urandom_range(0, 99) >= 36;
      end
    end
  end

  // long receiver stall
  always @(posedge clk) begin
    if (stall_req && !stall_used) begin
      hold_off <= STALL_CYCLES;
      stall_used <= 1'b1;
    end else if (hold_off > 0) begin
      hold_off <= hold_off - 1;
    end
  end

  // monitor
  always @(posedge clk) begin
    colour_t got, want;
    cycle_count <= cycle_count + 1;
    in_taken <= rst_n && in_valid && in_ready;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("%0t timeout", $time);
      $display("end of test: mismatches");
      $finish;
    end
    if (rst_n && in_valid && in_ready) begin
      predict_colours(vertex_t'({in_pos_x, in_pos_y, in_pos_z, in_line_start,
                                 in_line_end}));
      vertices_sent <= vertices_sent + 1;
    end
    if (rst_n && out_valid && out_ready) begin
      got = {out_tangent_x, out_tangent_y, out_tangent_z, out_local_red, out_local_green,
             out_local_blue, out_global_valid, out_global_red, out_global_green,
             out_global_blue, out_degenerate, out_run_last};
      results_seen <= results_seen + 1;
      if (expected_colours.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, got);
        errors <= errors + 1;
      end else begin
        want = expected_colours.pop_front();
        if (got !== want) begin
          $display("%0t mismatch: expected %h, actual %h", $time, want, got);
          errors <= errors + 1;
        end
      end
    end
  end

  task automatic push_line(int len, int kind);
    for (int i = 0; i < len; i++)
      pending_vertices.push_back(mk($signed(rand_coord(kind)), $signed(rand_coord(kind)),
                                    $signed(rand_coord(kind)), i == 0, i == len - 1));
  endtask

  initial begin
    int n;
    int pick;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // directed
    pending_vertices.push_back(mk(5, 5, 5, 0, 0));
    pending_vertices.push_back(mk(100, -7, 3, 1, 1));
    pending_vertices.push_back(mk(0, 0, 0, 1, 0));
    pending_vertices.push_back(mk(0, 0, 0, 0, 0));
    pending_vertices.push_back(mk(8388607, -8388608, 8388607, 0, 0));
    pending_vertices.push_back(mk(-8388608, 8388607, -8388608, 0, 1));
    pending_vertices.push_back(mk(1, 2, 3, 1, 0));
    pending_vertices.push_back(mk(1, 2, 3, 0, 1));
    pending_vertices.push_back(mk(10, 0, 0, 1, 0));
    pending_vertices.push_back(mk(0, 10, 0, 0, 0));
    pending_vertices.push_back(mk(10, 0, 0, 0, 1));
    pending_vertices.push_back(mk(-1, -1, -1, 1, 0));
    pending_vertices.push_back(mk(4, 4, 4, 1, 0));
    pending_vertices.push_back(mk(4, 4, -4, 0, 0));
    pending_vertices.push_back(mk(0, 0, 1, 0, 0));
    pending_vertices.push_back(mk(-4, 4, 0, 0, 1));
    pending_vertices.push_back(mk(7, 7, 7, 0, 1));
    pending_vertices.push_back(mk(1, 0, 0, 1, 0));
    pending_vertices.push_back(mk(0, 0, 0, 0, 1));
    // random
    n = 0;
    while (n < 1650) begin
      pick = $urandom_range(0, 9);
      if (pick < 8) begin
        int len = $urandom_range(1, 8);
        push_line(len, $urandom_range(0, 3));
        n += len;
      end else if (pick == 8) begin
        int cut = $urandom_range(1, 4);
        push_line(cut, 0);
        void'(pending_vertices.pop_back());
        n += cut - 1;
      end else begin
        pending_vertices.push_back(mk($signed(rand_coord(0)), $signed(rand_coord(0)),
                                      $signed(rand_coord(0)), 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1))));
        n += 1;
      end
      if (n > 400 && n < 420) stall_req = 1;
      if (n > 800 && n < 1100) calm = 1;
      else calm = 0;
      while (pending_vertices.size() > 40) @(posedge clk);
    end
    while (pending_vertices.size() != 0 || in_valid) @(posedge clk);
    while (expected_colours.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    $display("covered %0d vertex requests and %0d colour results, incl. long output stall",
             vertices_sent, results_seen);
    if (errors == 0 && expected_colours.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule
